// ===== rtl/kbd6kro_pkg.sv =====
`timescale 1ns / 1ps

package kbd6kro_pkg;

    localparam int NUM_KEY_SLOTS = 6;
    localparam int REPORT_KEYS   = 6;
    localparam int KEY_W         = 8;
    localparam int MOD_W         = 8;
    localparam int FUNC_W        = 3;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_KEY_DOWN    = 3'd0,
        FUNC_KEY_UP      = 3'd1,
        FUNC_RELEASE_ALL = 3'd2,
        FUNC_BUS_RESET   = 3'd3,
        FUNC_CONFIGURED  = 3'd4,
        FUNC_QUERY       = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK             = 2'd0,
        STATUS_NOT_CONFIGURED = 2'd1,
        STATUS_TABLE_FULL     = 2'd2
    } status_t;

    // command broadcast to every slot cell
    typedef struct packed {
        logic             clear;
        logic             insert;
        logic             remove;
        logic             code_nz;
        logic [KEY_W-1:0] code;
    } cell_cmd_t;

    // signals rippled from one cell to the next
    typedef struct packed {
        logic hit;
        logic claimed;
        logic hit_next;
    } cell_chain_t;

endpackage

// ===== rtl/kbd6kro_if.sv =====
`timescale 1ns / 1ps

interface kbd6kro_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] modifier_bits;
    logic [7:0] keycode;

    modport source (output valid, func, modifier_bits, keycode, input ready);
    modport sink   (input valid, func, modifier_bits, keycode, output ready);
endinterface

interface kbd6kro_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       send_report;
    logic [7:0] report_modifier;
    logic [7:0] report_key0;
    logic [7:0] report_key1;
    logic [7:0] report_key2;
    logic [7:0] report_key3;
    logic [7:0] report_key4;
    logic [7:0] report_key5;
    logic [2:0] pressed_count;
    logic       key_hit;

    modport source (
        output valid, status, send_report, report_modifier,
               report_key0, report_key1, report_key2, report_key3,
               report_key4, report_key5, pressed_count, key_hit,
        input  ready
    );
    modport sink (
        input  valid, status, send_report, report_modifier,
               report_key0, report_key1, report_key2, report_key3,
               report_key4, report_key5, pressed_count, key_hit,
        output ready
    );
endinterface

// ===== rtl/kbd6kro_slot_cell.sv =====
`timescale 1ns / 1ps

module kbd6kro_slot_cell
    import kbd6kro_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_cmd_t        cmd,
    input  cell_chain_t      chain_in,
    output cell_chain_t      chain_out,
    output logic [KEY_W-1:0] slot
);

    logic [KEY_W-1:0] slot_reg;
    logic [KEY_W-1:0] slot_next;
    logic             match;
    logic             empty;

    assign match = cmd.code_nz && (slot_reg == cmd.code);
    assign empty = (slot_reg == '0);

    always_comb
    begin
        slot_next = slot_reg;
        if (cmd.clear)
        begin
            slot_next = '0;
        end
        else if (cmd.insert && empty && !chain_in.claimed)
        begin
            // lowest empty slot takes the new code
            slot_next = cmd.code;
        end
        else if (cmd.remove && match && !chain_in.hit)
        begin
            slot_next = '0;
        end
    end

    assign chain_out.hit      = chain_in.hit | match;
    assign chain_out.claimed  = chain_in.claimed | empty;
    assign chain_out.hit_next = chain_in.hit_next
                              | (cmd.code_nz && (slot_next == cmd.code));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot = slot_reg;

endmodule

// ===== rtl/keyboard_6kro_report_tracker.sv =====
`timescale 1ns / 1ps

// channel | role | payload
// --------+------+--------------------------------------------------------------
// req     | sink | func, modifier_bits, keycode
// rsp     | src  | status, send_report, report_modifier, report_key0..5,
//         |      | pressed_count, key_hit
//
// one transfer on req per cycle; its result is registered and shown on rsp
// the next cycle. the whole update is combinational through a ripple of six
// slot cells (match, lowest-empty pick and post-update hit are chained).
// req.ready drops only while a result waits in the output register and
// rsp.ready is low; a new transfer is taken in the cycle the result leaves.
// reset clears the modifier, all slots, the count and the configured flag.

module keyboard_6kro_report_tracker
    import kbd6kro_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    kbd6kro_req_if.sink   req,
    kbd6kro_rsp_if.source rsp
);

    // tracker state
    logic [MOD_W-1:0]   mod_reg;
    logic [MOD_W-1:0]   mod_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               cfg_reg;
    logic               cfg_next;

    // result register
    logic               rsp_valid_reg;
    status_t            status_reg;
    status_t            status_next;
    logic               send_reg;
    logic               send_next;
    logic [MOD_W-1:0]   rmod_reg;
    logic [COUNT_W-1:0] rcount_reg;
    logic               hit_reg;

    logic               accept;
    func_t              func;
    cell_cmd_t          cmd;
    cell_chain_t        chain [NUM_KEY_SLOTS+1];
    logic [KEY_W-1:0]   slot_val [NUM_KEY_SLOTS];
    logic [KEY_W-1:0]   key_view [REPORT_KEYS];
    logic               present;
    logic               full;
    logic [NUM_KEY_SLOTS-1:0] slot_used;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign func      = func_t'(req.func);

    assign chain[0] = '0;
    assign present  = chain[NUM_KEY_SLOTS].hit;
    assign full     = !chain[NUM_KEY_SLOTS].claimed;

    // slot cell row, each cell keeps one keycode
    for (genvar i = 0; i < NUM_KEY_SLOTS; i++)
    begin : g_cell
        kbd6kro_slot_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1]),
            .slot      (slot_val[i])
        );
        assign slot_used[i] = (slot_val[i] != '0);
    end

    // slots beyond the configured row read as empty
    for (genvar k = 0; k < REPORT_KEYS; k++)
    begin : g_view
        if (k < NUM_KEY_SLOTS)
        begin : g_live
            assign key_view[k] = slot_val[k];
        end
        else
        begin : g_zero
            assign key_view[k] = '0;
        end
    end

    // function decode
    always_comb
    begin
        mod_next    = mod_reg;
        count_next  = count_reg;
        cfg_next    = cfg_reg;
        status_next = STATUS_OK;
        send_next   = 1'b0;
        cmd.clear   = 1'b0;
        cmd.insert  = 1'b0;
        cmd.remove  = 1'b0;
        cmd.code_nz = (req.keycode != '0);
        cmd.code    = req.keycode;
        if (accept)
        begin
            unique case (func)
                FUNC_KEY_DOWN:
                begin
                    if (!cfg_reg)
                    begin
                        status_next = STATUS_NOT_CONFIGURED;
                    end
                    else
                    begin
                        mod_next = mod_reg | req.modifier_bits;
                        if (cmd.code_nz && !present)
                        begin
                            if (full)
                            begin
                                status_next = STATUS_TABLE_FULL;
                            end
                            else
                            begin
                                cmd.insert = 1'b1;
                                count_next = COUNT_W'(count_reg + 1'b1);
                            end
                        end
                        send_next = (status_next == STATUS_OK);
                    end
                end
                FUNC_KEY_UP:
                begin
                    if (!cfg_reg)
                    begin
                        status_next = STATUS_NOT_CONFIGURED;
                    end
                    else
                    begin
                        mod_next   = mod_reg & ~req.modifier_bits;
                        cmd.remove = 1'b1;
                        if (present && (count_reg != '0))
                        begin
                            count_next = COUNT_W'(count_reg - 1'b1);
                        end
                        send_next = 1'b1;
                    end
                end
                FUNC_RELEASE_ALL:
                begin
                    cmd.clear  = 1'b1;
                    mod_next   = '0;
                    count_next = '0;
                    if (cfg_reg)
                    begin
                        send_next = 1'b1;
                    end
                    else
                    begin
                        status_next = STATUS_NOT_CONFIGURED;
                    end
                end
                FUNC_BUS_RESET:
                begin
                    cmd.clear  = 1'b1;
                    mod_next   = '0;
                    count_next = '0;
                    cfg_next   = 1'b0;
                end
                FUNC_CONFIGURED:
                begin
                    cmd.clear  = 1'b1;
                    mod_next   = '0;
                    count_next = '0;
                    cfg_next   = 1'b1;
                end
                default:
                begin
                    // query and unused codes leave the state alone
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg       <= '0;
            count_reg     <= '0;
            cfg_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            mod_reg   <= mod_next;
            count_reg <= count_next;
            cfg_reg   <= cfg_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, slots shown after the update lands
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            send_reg   <= send_next;
            rmod_reg   <= mod_next;
            rcount_reg <= count_next;
            hit_reg    <= chain[NUM_KEY_SLOTS].hit_next;
        end
    end

    // report keys read the slot registers directly; they only change on a
    // new transfer, so they hold still while the result waits
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.send_report     = send_reg;
    assign rsp.report_modifier = rmod_reg;
    assign rsp.report_key0     = key_view[0];
    assign rsp.report_key1     = key_view[1];
    assign rsp.report_key2     = key_view[2];
    assign rsp.report_key3     = key_view[3];
    assign rsp.report_key4     = key_view[4];
    assign rsp.report_key5     = key_view[5];
    assign rsp.pressed_count   = rcount_reg;
    assign rsp.key_hit         = hit_reg;

    // count tracks the occupied slots
    a_count_matches_slots: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(slot_used) == int'(count_reg))
        else $error("pressed count does not match occupied slots");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= NUM_KEY_SLOTS)
        else $error("pressed count above slot count");

    a_bus_reset_unconfigures: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.func == FUNC_BUS_RESET) |=> !cfg_reg)
        else $error("bus reset left the configured flag set");

    a_full_no_report: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (status_reg == STATUS_TABLE_FULL) |-> !send_reg)
        else $error("report requested on a full table");

    a_unconfigured_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cfg_reg
        && ((req.func == FUNC_KEY_DOWN) || (req.func == FUNC_KEY_UP))
        |=> $stable(count_reg) && $stable(mod_reg))
        else $error("key change taken while unconfigured");

endmodule
